### rtl/access_history_window_counter_assert.svh
// Assertion macros used by the checker file.
`ifndef ACCESS_HISTORY_WINDOW_COUNTER_ASSERT_SVH
`define ACCESS_HISTORY_WINDOW_COUNTER_ASSERT_SVH

// Property checked only while out of reset.
`define AHWC_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("access history window counter check failed");

// Property checked at every edge, reset included.
`define AHWC_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("access history window counter reset check failed");

`endif

### rtl/ahwc_pkg.sv
`timescale 1ns / 1ps

package ahwc_pkg;

    // Field widths fixed by the interface
    localparam int CNT_W    = 9;
    localparam int SAMPLE_W = 2;

    // Sample codes
    localparam logic [SAMPLE_W-1:0] SAMPLE_NONE   = 2'd0;
    localparam logic [SAMPLE_W-1:0] SAMPLE_READ   = 2'd1;
    localparam logic [SAMPLE_W-1:0] SAMPLE_WRITE  = 2'd2;
    localparam logic [SAMPLE_W-1:0] SAMPLE_UNUSED = 2'd3;

    // Window length after reset
    localparam logic [CNT_W-1:0] WIN_LEN_RESET = 9'd256;

endpackage

### rtl/access_history_window_counter.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// in        request    i_in_valid / o_in_stall   i_new_value, i_clear
// out       result     o_out_valid / i_out_stall o_read_count, o_write_count,
//                                                o_idle_count, o_evicted_value
// cfg       write      i_cfg_we                  i_cfg_wdata (window length)
//
// One request per cycle sustained while the result does not stall; an accepted
// request passes the input register, then one slot read-modify-write, into the
// result register. The history slot at the next position is prefetched into a
// register, so the single memory read port keeps up with the request rate.
// Reset is synchronous: no clearing pass, a fill count marks which slots
// were written since the last reset or clear request; others read as none.
// A stalled result holds; the input register keeps one request while the
// result stalls, then o_in_stall rises.

module access_history_window_counter #(
    parameter int MAX_WINDOW = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [ahwc_pkg::SAMPLE_W-1:0]     i_new_value,
    input  logic                              i_clear,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [ahwc_pkg::CNT_W-1:0]        o_read_count,
    output logic [ahwc_pkg::CNT_W-1:0]        o_write_count,
    output logic [ahwc_pkg::CNT_W-1:0]        o_idle_count,
    output logic [ahwc_pkg::SAMPLE_W-1:0]     o_evicted_value,
    // window length register
    input  logic                              i_cfg_we,
    input  logic [ahwc_pkg::CNT_W-1:0]        i_cfg_wdata
);

    localparam int CW = ahwc_pkg::CNT_W;
    localparam int SW = ahwc_pkg::SAMPLE_W;
    localparam int AW = $clog2(MAX_WINDOW);
    localparam int PW = (AW + 1 > CW) ? AW + 1 : CW;
    localparam int MAX_LEN_I = (MAX_WINDOW > (1 << CW) - 1) ? (1 << CW) - 1 : MAX_WINDOW;
    localparam logic [CW-1:0] MAX_LEN = CW'(MAX_LEN_I);

    // state
    logic [CW-1:0]  r_win_len;
    logic           r_in_valid;
    logic [SW-1:0]  r_nv;
    logic           r_clr;
    logic [AW-1:0]  r_pos;
    logic [AW:0]    r_fill;
    logic [SW-1:0]  r_slot;
    logic [CW-1:0]  r_rd;
    logic [CW-1:0]  r_wr;
    logic [SW-1:0]  r_hist [MAX_WINDOW];
    logic           r_out_valid;
    logic [CW-1:0]  r_out_rd;
    logic [CW-1:0]  r_out_wr;
    logic [CW-1:0]  r_out_idle;
    logic [SW-1:0]  r_out_evict;

    logic [AW-1:0]  n_pos;
    logic [AW:0]    n_fill;
    logic [CW-1:0]  n_rd;
    logic [CW-1:0]  n_wr;
    logic [CW-1:0]  n_idle;
    logic [SW-1:0]  n_evict;

    logic           w_fire;
    logic           w_accept;
    logic           w_wr_en;
    logic [CW-1:0]  w_len;
    logic [SW-1:0]  w_nv;
    logic [CW-1:0]  w_rd_dec;
    logic [CW-1:0]  w_wr_dec;
    logic [PW-1:0]  w_pos_inc;
    logic [CW:0]    w_busy;

    // handshake
    assign w_fire     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_fire;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_wr_en    = w_fire && !r_clr;

    // effective length: zero acts as one, capped at store depth and count max
    always_comb begin
        if (r_win_len == '0) begin
            w_len = CW'(1);
        end else if (r_win_len > MAX_LEN) begin
            w_len = MAX_LEN;
        end else begin
            w_len = r_win_len;
        end
    end

    // unused sample code records as none
    assign w_nv = (r_nv == ahwc_pkg::SAMPLE_UNUSED) ? ahwc_pkg::SAMPLE_NONE : r_nv;

    // slot update, tallies and position
    always_comb begin
        n_pos     = r_pos;
        n_fill    = r_fill;
        n_rd      = r_rd;
        n_wr      = r_wr;
        n_evict   = ahwc_pkg::SAMPLE_NONE;
        w_rd_dec  = r_rd;
        w_wr_dec  = r_wr;
        w_pos_inc = PW'(r_pos) + PW'(1);
        if (w_fire) begin
            if (r_clr) begin
                n_pos  = '0;
                n_fill = '0;
                n_rd   = '0;
                n_wr   = '0;
            end else begin
                // slots at or beyond the fill count were not written since clear
                if ((AW + 1)'(r_pos) < r_fill) begin
                    n_evict = r_slot;
                end
                if ((AW + 1)'(r_pos) == r_fill) begin
                    n_fill = r_fill + (AW + 1)'(1);
                end
                if (n_evict == ahwc_pkg::SAMPLE_READ && r_rd != '0) begin
                    w_rd_dec = r_rd - CW'(1);
                end
                if (n_evict == ahwc_pkg::SAMPLE_WRITE && r_wr != '0) begin
                    w_wr_dec = r_wr - CW'(1);
                end
                n_rd = w_rd_dec;
                n_wr = w_wr_dec;
                if (w_nv == ahwc_pkg::SAMPLE_READ && w_rd_dec < w_len) begin
                    n_rd = w_rd_dec + CW'(1);
                end
                if (w_nv == ahwc_pkg::SAMPLE_WRITE && w_wr_dec < w_len) begin
                    n_wr = w_wr_dec + CW'(1);
                end
                n_pos = (w_pos_inc >= PW'(w_len)) ? '0 : w_pos_inc[AW-1:0];
            end
        end
    end

    // idle count saturates at zero
    assign w_busy = (CW + 1)'(n_rd) + (CW + 1)'(n_wr);
    assign n_idle = (w_busy > (CW + 1)'(w_len)) ? '0 : CW'((CW + 1)'(w_len) - w_busy);

    // history memory: write the current slot, prefetch the next one
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_hist[r_pos] <= w_nv;
        end
        if (w_wr_en && n_pos == r_pos) begin
            r_slot <= w_nv;
        end else begin
            r_slot <= r_hist[n_pos];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len   <= ahwc_pkg::WIN_LEN_RESET;
            r_in_valid  <= 1'b0;
            r_pos       <= '0;
            r_fill      <= '0;
            r_rd        <= '0;
            r_wr        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_win_len <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            r_pos  <= n_pos;
            r_fill <= n_fill;
            r_rd   <= n_rd;
            r_wr   <= n_wr;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_nv  <= i_new_value;
            r_clr <= i_clear;
        end
        if (w_fire) begin
            r_out_rd    <= n_rd;
            r_out_wr    <= n_wr;
            r_out_idle  <= n_idle;
            r_out_evict <= n_evict;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_read_count    = r_out_rd;
    assign o_write_count   = r_out_wr;
    assign o_idle_count    = r_out_idle;
    assign o_evicted_value = r_out_evict;

endmodule

### rtl/ahwc_checker.sv
`timescale 1ns / 1ps
`include "access_history_window_counter_assert.svh"

module ahwc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [ahwc_pkg::CNT_W-1:0]     o_read_count,
    input logic [ahwc_pkg::CNT_W-1:0]     o_write_count,
    input logic [ahwc_pkg::CNT_W-1:0]     o_idle_count,
    input logic [ahwc_pkg::SAMPLE_W-1:0]  o_evicted_value
);

    // reset empties the result register
    `AHWC_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !o_out_valid)

    // the history only ever holds legal sample codes
    `AHWC_ASSERT(a_evict_legal, i_clk, i_rst_n,
        o_out_valid |-> o_evicted_value != ahwc_pkg::SAMPLE_UNUSED)

    // a stalled result holds
    `AHWC_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_read_count)
            && $stable(o_write_count) && $stable(o_idle_count)
            && $stable(o_evicted_value))

    // an accepted request reaches the result register once the output frees up
    `AHWC_ASSERT(a_result_follows, i_clk, i_rst_n,
        (i_in_valid && !o_in_stall) ##1 (!o_out_valid || !i_out_stall) |=> o_out_valid)

endmodule

bind access_history_window_counter ahwc_checker u_ahwc_checker (.*);

### tb/access_history_window_counter_test.sv
`timescale 1ns / 1ps

module access_history_window_counter_test;

    localparam int CNT_W          = ahwc_pkg::CNT_W;
    localparam int SAMPLE_W       = ahwc_pkg::SAMPLE_W;
    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 12;
    localparam int MAX_WIN        = 256;
    localparam int DRAIN_CYCLES   = 4;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    // One result of the block
    typedef struct packed {
        logic [CNT_W-1:0]    reads;
        logic [CNT_W-1:0]    writes;
        logic [CNT_W-1:0]    idle;
        logic [SAMPLE_W-1:0] evicted;
    } t_tally;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [SAMPLE_W-1:0] i_new_value = ahwc_pkg::SAMPLE_NONE;
    logic                i_clear = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [CNT_W-1:0]    o_read_count;
    logic [CNT_W-1:0]    o_write_count;
    logic [CNT_W-1:0]    o_idle_count;
    logic [SAMPLE_W-1:0] o_evicted_value;
    logic                i_cfg_we = 1'b0;
    logic [CNT_W-1:0]    i_cfg_wdata = '0;

    // Shadow state of the window
    logic [SAMPLE_W-1:0] history_copy [MAX_WIN];
    logic [CNT_W-1:0]    window_setting;
    int                  slot_copy;
    int                  read_copy;
    int                  write_copy;

    t_tally pending_tallies[$];
    int     error_count = 0;
    int     quiet_cycles = 0;
    bit     pace_idle = 1'b1;
    bit     hold_req = 1'b0;

    access_history_window_counter #(
        .MAX_WINDOW(MAX_WIN)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_new_value    (i_new_value),
        .i_clear        (i_clear),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_read_count   (o_read_count),
        .o_write_count  (o_write_count),
        .o_idle_count   (o_idle_count),
        .o_evicted_value(o_evicted_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Wipe history, tallies and position of the shadow window
    function automatic void clear_window_copy();
        for (int i = 0; i < MAX_WIN; i++) history_copy[i] = ahwc_pkg::SAMPLE_NONE;
        slot_copy  = 0;
        read_copy  = 0;
        write_copy = 0;
    endfunction

    // Apply one request to the shadow window and return the tallies it yields
    function automatic t_tally predict_tallies(input logic [SAMPLE_W-1:0] sample,
                                               input logic clr);
        int                  len;
        int                  slot;
        int                  busy;
        logic [SAMPLE_W-1:0] kind;
        logic [SAMPLE_W-1:0] old;
        t_tally              r;
        if (window_setting == 0)
            len = 1;
        else if (window_setting > MAX_WIN)
            len = MAX_WIN;
        else
            len = window_setting;
        kind = (sample == ahwc_pkg::SAMPLE_UNUSED) ? ahwc_pkg::SAMPLE_NONE : sample;
        old  = ahwc_pkg::SAMPLE_NONE;
        if (clr) begin
            clear_window_copy();
        end else begin
            slot = slot_copy % MAX_WIN;
            old  = history_copy[slot];
            history_copy[slot] = kind;
            if (old == ahwc_pkg::SAMPLE_READ && read_copy > 0)
                read_copy--;
            else if (old == ahwc_pkg::SAMPLE_WRITE && write_copy > 0)
                write_copy--;
            if (kind == ahwc_pkg::SAMPLE_READ && read_copy < len)
                read_copy++;
            else if (kind == ahwc_pkg::SAMPLE_WRITE && write_copy < len)
                write_copy++;
            slot_copy = (slot + 1 >= len) ? 0 : slot + 1;
        end
        busy      = read_copy + write_copy;
        r.reads   = CNT_W'(read_copy);
        r.writes  = CNT_W'(write_copy);
        r.idle    = (busy > len) ? '0 : CNT_W'(len - busy);
        r.evicted = old;
        return r;
    endfunction

    task automatic report_error(input string msg);
        $display("%0t ERROR %s", $time, msg);
        error_count++;
    endtask

    // Offer one request after a random gap; record its prediction on acceptance
    task automatic send_request(input logic [SAMPLE_W-1:0] sample, input logic clr);
        int gap;
        gap = pace_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_new_value <= sample;
        i_clear     <= clr;
        do @(posedge i_clk); while (o_in_stall);
        pending_tallies.push_back(predict_tallies(sample, clr));
    endtask

    // Drop valid and let every outstanding result come back
    task automatic wait_until_idle();
        i_in_valid <= 1'b0;
        while (pending_tallies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_window(input logic [CNT_W-1:0] value);
        wait_until_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        window_setting  = value;
    endtask

    // Draw a sample code: mostly reads and writes, some none, a few unused
    function automatic logic [SAMPLE_W-1:0] draw_sample();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) return ahwc_pkg::SAMPLE_READ;
        if (pick < 80) return ahwc_pkg::SAMPLE_WRITE;
        if (pick < 92) return ahwc_pkg::SAMPLE_NONE;
        return ahwc_pkg::SAMPLE_UNUSED;
    endfunction

    // Default window after reset, every sample code, clear
    task automatic test_default_window();
        send_request(ahwc_pkg::SAMPLE_READ, 1'b0);
        send_request(ahwc_pkg::SAMPLE_WRITE, 1'b0);
        send_request(ahwc_pkg::SAMPLE_NONE, 1'b0);
        send_request(ahwc_pkg::SAMPLE_UNUSED, 1'b0);
        send_request(ahwc_pkg::SAMPLE_UNUSED, 1'b1);
        send_request(ahwc_pkg::SAMPLE_WRITE, 1'b0);
    endtask

    // Length of one, zero acting as one, a length above the maximum
    task automatic test_length_extremes();
        set_window(9'd1);
        send_request(ahwc_pkg::SAMPLE_READ, 1'b0);
        send_request(ahwc_pkg::SAMPLE_WRITE, 1'b0);
        send_request(ahwc_pkg::SAMPLE_UNUSED, 1'b0);
        send_request(ahwc_pkg::SAMPLE_READ, 1'b0);
        set_window(9'd0);
        send_request(ahwc_pkg::SAMPLE_WRITE, 1'b0);
        send_request(ahwc_pkg::SAMPLE_READ, 1'b1);
        set_window(9'd511);
        send_request(ahwc_pkg::SAMPLE_READ, 1'b0);
        send_request(ahwc_pkg::SAMPLE_WRITE, 1'b1);
    endtask

    // Shrink below the tallies: increments blocked, idle count saturates
    task automatic test_runtime_resize();
        set_window(9'd6);
        send_request(ahwc_pkg::SAMPLE_NONE, 1'b1);
        repeat (6) send_request(ahwc_pkg::SAMPLE_READ, 1'b0);
        set_window(9'd3);
        send_request(ahwc_pkg::SAMPLE_READ, 1'b0);
        send_request(ahwc_pkg::SAMPLE_WRITE, 1'b0);
        set_window(9'd9);
        send_request(ahwc_pkg::SAMPLE_NONE, 1'b0);
    endtask

    // Random lengths, random samples, occasional clear
    task automatic test_random_phases();
        logic [CNT_W-1:0] len;
        for (int phase = 0; phase < 4; phase++) begin
            case ($urandom_range(0, 6))
                0:       len = 9'd0;
                1:       len = 9'd1;
                2:       len = 9'd2;
                3:       len = CNT_W'($urandom_range(3, 16));
                4:       len = CNT_W'($urandom_range(17, 255));
                5:       len = 9'd256;
                default: len = CNT_W'($urandom_range(257, 511));
            endcase
            set_window(len);
            pace_idle = (phase != 2);
            repeat (100) begin
                if ($urandom_range(0, 99) < 3)
                    send_request(draw_sample(), 1'b1);
                else
                    send_request(draw_sample(), 1'b0);
            end
        end
        pace_idle = 1'b1;
    endtask

    // Fill the largest window with reads, then overwrite them with writes
    task automatic test_full_window();
        set_window(9'd256);
        send_request(ahwc_pkg::SAMPLE_READ, 1'b1);
        repeat (260) send_request(ahwc_pkg::SAMPLE_READ, 1'b0);
        pace_idle = 1'b0;
        repeat (260) send_request(ahwc_pkg::SAMPLE_WRITE, 1'b0);
        pace_idle = 1'b1;
    endtask

    // Long result stall while requests keep coming
    task automatic test_backpressure();
        set_window(CNT_W'($urandom_range(2, 40)));
        pace_idle = 1'b0;
        hold_req  = 1'b1;
        repeat (40) send_request(draw_sample(), 1'b0);
        pace_idle = 1'b1;
    endtask

    // Result-side stall pacing, with a long hold when requested
    initial begin : result_pacing
        int n;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                n = pace_idle ? $urandom_range(0, 10) : 0;
                if (n > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_tally want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_tallies.size() == 0) begin
                report_error("result with no request pending");
            end else begin
                want = pending_tallies.pop_front();
                if (o_read_count !== want.reads)
                    report_error($sformatf("read_count %0d expected %0d",
                                           o_read_count, want.reads));
                if (o_write_count !== want.writes)
                    report_error($sformatf("write_count %0d expected %0d",
                                           o_write_count, want.writes));
                if (o_idle_count !== want.idle)
                    report_error($sformatf("idle_count %0d expected %0d",
                                           o_idle_count, want.idle));
                if (o_evicted_value !== want.evicted)
                    report_error($sformatf("evicted_value %0d expected %0d",
                                           o_evicted_value, want.evicted));
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("access_history_window_counter_test: FAIL");
            $finish;
        end
    end

    initial begin
        window_setting = ahwc_pkg::WIN_LEN_RESET;
        clear_window_copy();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_window();
        test_length_extremes();
        test_runtime_resize();
        test_random_phases();
        test_full_window();
        test_backpressure();
        wait_until_idle();
        if (error_count == 0) begin
            $display("access_history_window_counter_test: PASS");
        end else begin
            $display("access_history_window_counter_test: FAIL");
        end
        $finish;
    end

endmodule
